@@ hw/rtl/smm_pkg.sv @@
// Shared constants, codes and structs for the square matrix multiply block.
// No dependencies; imported by every module of the block but smm_ram.
package smm_pkg;

    localparam int MAX_DIM    = 8;
    localparam int DATA_WIDTH = 32;

    // Fixed field widths on the ports
    localparam int IDX_W   = 3;
    localparam int VALUE_W = 32;
    localparam int SIZE_W  = 4;
    localparam int FUNC_W  = 2;
    localparam int TDATA_W = ((2 * IDX_W + VALUE_W + 7) / 8) * 8;

    // Internal index and address widths
    localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ADDR_W = 2 * DIM_W;
    localparam int DEPTH  = 1 << ADDR_W;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WR_A    = 2'd0,
        FUNC_WR_B    = 2'd1,
        FUNC_COMPUTE = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_ISSUE,
        ST_DRAIN
    } seq_state_t;

    // Element write into the A or B store
    typedef struct packed {
        logic                  we_a;
        logic                  we_b;
        logic [ADDR_W-1:0]     addr;
        logic [DATA_WIDTH-1:0] data;
    } mem_wr_t;

    // Tag that travels with one multiply-accumulate step
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last_k;
        logic             last_elem;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
    } mac_tag_t;

    // Finished product element
    typedef struct packed {
        logic                  valid;
        logic                  last;
        logic [DIM_W-1:0]      row;
        logic [DIM_W-1:0]      col;
        logic [DATA_WIDTH-1:0] sum;
    } mac_res_t;

endpackage

@@ hw/rtl/smm_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module smm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/smm_mac.sv @@
// Multiply-accumulate pipeline: aligns tags with RAM read data, registers the
// product, accumulates one dot product at a time. Depends on smm_pkg.
module smm_mac
    import smm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mac_tag_t              tag,
    input  logic [DATA_WIDTH-1:0] a_data,
    input  logic [DATA_WIDTH-1:0] b_data,
    output mac_res_t              res
);

    mac_tag_t                tag_d1_reg, tag_d2_reg;
    logic [DATA_WIDTH-1:0]   prod_reg, prod_next;
    logic [2*DATA_WIDTH-1:0] prod_full;
    logic [DATA_WIDTH-1:0]   acc_reg, acc_next;
    mac_res_t                res_reg, res_next;

    // low bits of the product are the same signed or unsigned
    assign prod_full = a_data * b_data;
    assign prod_next = prod_full[DATA_WIDTH-1:0];

    always_comb begin
        acc_next = (tag_d2_reg.first ? '0 : acc_reg) + prod_reg;
        res_next.valid = tag_d2_reg.valid && tag_d2_reg.last_k;
        res_next.last  = tag_d2_reg.last_elem;
        res_next.row   = tag_d2_reg.row;
        res_next.col   = tag_d2_reg.col;
        res_next.sum   = acc_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_d1_reg <= '0;
            tag_d2_reg <= '0;
            res_reg    <= '0;
        end else begin
            tag_d1_reg <= tag;
            tag_d2_reg <= tag_d1_reg;
            res_reg    <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (tag_d2_reg.valid) begin
            acc_reg <= acc_next;
        end
    end

    assign res = res_reg;

endmodule

@@ hw/rtl/smm_seq.sv @@
// Request decoder and compute sequencer: element writes, then the i/j/k walk
// over the stores for a compute request. Depends on smm_pkg.
module smm_seq
    import smm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,
    input  logic [FUNC_W-1:0]  s_tuser,
    input  logic [SIZE_W-1:0]  size_in_use,
    input  logic               out_free,
    input  logic               mac_done,
    output mem_wr_t            wr,
    output logic [ADDR_W-1:0]  rd_addr_a,
    output logic [ADDR_W-1:0]  rd_addr_b,
    output mac_tag_t           tag
);

    seq_state_t       state_reg, state_next;
    logic [DIM_W-1:0] n_m1_reg, n_m1_next;
    logic [DIM_W-1:0] i_reg, i_next;
    logic [DIM_W-1:0] j_reg, j_next;
    logic [DIM_W-1:0] k_reg, k_next;

    logic                  accept;
    logic [IDX_W-1:0]      row_in, col_in;
    logic signed [VALUE_W-1:0] val_in;
    logic                  in_range;
    logic [DIM_W-1:0]      eff_m1;
    logic                  last_elem;

    assign row_in   = s_tdata[IDX_W-1:0];
    assign col_in   = s_tdata[2*IDX_W-1:IDX_W];
    assign val_in   = s_tdata[2*IDX_W +: VALUE_W];
    assign in_range = (int'(row_in) < MAX_DIM) && (int'(col_in) < MAX_DIM);
    assign accept   = s_tvalid && s_tready;
    assign last_elem = (i_reg == n_m1_reg) && (j_reg == n_m1_reg);

    // size 0 acts as 1, above MAX_DIM acts as MAX_DIM
    always_comb begin
        if (size_in_use == '0) begin
            eff_m1 = '0;
        end else if ({1'b0, size_in_use} > (SIZE_W+1)'(MAX_DIM)) begin
            eff_m1 = DIM_W'(MAX_DIM - 1);
        end else begin
            eff_m1 = DIM_W'(size_in_use - 1'b1);
        end
    end

    always_comb begin
        wr.we_a = accept && (s_tuser == FUNC_WR_A) && in_range;
        wr.we_b = accept && (s_tuser == FUNC_WR_B) && in_range;
        wr.addr = {DIM_W'(row_in), DIM_W'(col_in)};
        wr.data = DATA_WIDTH'(val_in);
    end

    always_comb begin
        state_next = state_reg;
        n_m1_next  = n_m1_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        s_tready   = 1'b0;
        tag        = '0;
        rd_addr_a  = {i_reg, k_reg};
        rd_addr_b  = {k_reg, j_reg};

        unique case (state_reg)
            ST_IDLE: begin
                // ready is high here, so valid alone marks a request
                s_tready = 1'b1;
                if (s_tvalid && (s_tuser == FUNC_COMPUTE)) begin
                    n_m1_next  = eff_m1;
                    i_next     = '0;
                    j_next     = '0;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                k_next = '0;
                if (out_free) begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                tag.valid     = 1'b1;
                tag.first     = (k_reg == '0);
                tag.last_k    = (k_reg == n_m1_reg);
                tag.last_elem = last_elem;
                tag.row       = i_reg;
                tag.col       = j_reg;
                k_next        = k_reg + 1'b1;
                if (k_reg == n_m1_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (mac_done) begin
                    if (last_elem) begin
                        state_next = ST_IDLE;
                    end else begin
                        if (j_reg == n_m1_reg) begin
                            j_next = '0;
                            i_next = i_reg + 1'b1;
                        end else begin
                            j_next = j_reg + 1'b1;
                        end
                        state_next = ST_START;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            n_m1_reg  <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            n_m1_reg  <= n_m1_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

endmodule

@@ hw/rtl/square_matrix_multiply_top.sv @@
// Top level of the square matrix multiply block: A and B stores, sequencer,
// multiply-accumulate pipeline and output register. Depends on smm_pkg,
// smm_ram, smm_seq and smm_mac.
//
// Usage:
//   s_ channel: one request per handshake. s_tuser is the function (write A,
//   write B, compute); a write stores s_tdata's element at row/column.
//   Writes are taken one per cycle while the block is idle.
//   A compute request walks the stores and emits n*n product elements on the
//   m_ channel in row-major order, m_tlast high on the final one.
//   Each element is one dot product: n reads from each store, one per cycle,
//   through a read, multiply and accumulate pipeline. The next element
//   starts once the output register is free. The single read port of each
//   store sets the pace of one step per cycle.
//   s_tready stays low from a compute request until its last element has
//   left the pipeline; a stalled receiver simply holds the walk at the next
//   element start, nothing is dropped.
//   cfg_ channel: the size register n (1..8, 0 acts as 1, above 8 acts as
//   8), which the user must write only while idle (not enforced); it is sampled
//   when a compute is accepted. Reset (aresetn low, synchronous) sets n to 8
//   and empties the pipeline; store contents are undefined until written.
module square_matrix_multiply_top
    import smm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // request channel
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // row_index[2:0], col_index[5:3], element_value[37:6]
    input  logic [FUNC_W-1:0]  s_tuser,   // func[1:0]
    // result channel
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // out_row[2:0], out_col[5:3], product_value[37:6]
    output logic               m_tlast,
    // size register
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [SIZE_W-1:0]  cfg_data
);

    logic [SIZE_W-1:0]     size_reg;
    mem_wr_t               wr;
    logic [ADDR_W-1:0]     rd_addr_a, rd_addr_b;
    logic [DATA_WIDTH-1:0] a_data, b_data;
    mac_tag_t              tag;
    mac_res_t              mac_res;
    logic                  out_free;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic                  m_tlast_reg;
    logic [IDX_W-1:0]      out_row_reg, out_col_reg;
    logic [VALUE_W-1:0]    product_reg;

    // size register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= SIZE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            size_reg <= cfg_data;
        end
    end

    // output slot is free when empty or being taken this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    smm_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .size_in_use (size_reg),
        .out_free    (out_free),
        .mac_done    (mac_res.valid),
        .wr          (wr),
        .rd_addr_a   (rd_addr_a),
        .rd_addr_b   (rd_addr_b),
        .tag         (tag)
    );

    smm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram_a (
        .aclk  (aclk),
        .we    (wr.we_a),
        .waddr (wr.addr),
        .wdata (wr.data),
        .raddr (rd_addr_a),
        .rdata (a_data)
    );

    smm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram_b (
        .aclk  (aclk),
        .we    (wr.we_b),
        .waddr (wr.addr),
        .wdata (wr.data),
        .raddr (rd_addr_b),
        .rdata (b_data)
    );

    smm_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tag     (tag),
        .a_data  (a_data),
        .b_data  (b_data),
        .res     (mac_res)
    );

    // output register; the sequencer only starts an element into a free slot
    always_comb begin
        if (mac_res.valid) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mac_res.valid) begin
            out_row_reg <= IDX_W'(mac_res.row);
            out_col_reg <= IDX_W'(mac_res.col);
            product_reg <= VALUE_W'(mac_res.sum);
            m_tlast_reg <= mac_res.last;
        end
    end

    always_comb begin
        m_tdata                          = '0;
        m_tdata[IDX_W-1:0]               = out_row_reg;
        m_tdata[2*IDX_W-1:IDX_W]         = out_col_reg;
        m_tdata[2*IDX_W +: VALUE_W]      = product_reg;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;

    // a finished element never lands on an unsent one
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_res.valid |-> !m_tvalid_reg)
        else $error("product element arrived while output register still full");

    // no request is taken while a product is still in the pipeline
    a_busy_while_result: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_res.valid |-> !s_tready)
        else $error("request channel open while compute in progress");

    // the final element returns the block to idle on the next cycle
    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (mac_res.valid && mac_res.last) |=> s_tready)
        else $error("block not idle after final product element");

endmodule

@@ tb/sv/tb_square_matrix_multiply_top.sv @@
// Self-checking testbench for square_matrix_multiply_top: loads A and B
// elements, issues compute requests and checks every product element.
// Depends on smm_pkg and the block's RTL; needs no files or arguments.
module tb_square_matrix_multiply_top;
    import smm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Code outside func_t that the block must ignore
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS  = 110;
    localparam int SETTLE_CYCLES = 20;   // quiet time before a size write
    localparam int HOLD_CYCLES   = 400;  // long receiver back-pressure
    localparam int CELLS         = MAX_DIM * MAX_DIM;

    // One product element as it should appear on the m_ side
    typedef struct {
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic [VALUE_W-1:0] value;
        logic               last;
    } product_elem_t;

    // Tracks the A/B stores and size, predicts the product stream and
    // compares it against what the block emits.
    class product_tracker;
        logic [DATA_WIDTH-1:0] a_store[CELLS];
        logic [DATA_WIDTH-1:0] b_store[CELLS];
        bit                    a_loaded[CELLS];
        bit                    b_loaded[CELLS];
        logic [SIZE_W-1:0]     dim_reg = SIZE_RESET;
        product_elem_t         pending_elements[$];
        int                    mismatch_count = 0;

        // 0 acts as 1, anything above MAX_DIM acts as MAX_DIM
        function int active_dim();
            if (dim_reg == 0)
                return 1;
            if (dim_reg > MAX_DIM)
                return MAX_DIM;
            return int'(dim_reg);
        endfunction

        function void set_dim(logic [SIZE_W-1:0] v);
            dim_reg = v;
        endfunction

        // Called once per accepted request
        function void take_request(logic [FUNC_W-1:0] func, logic [IDX_W-1:0] row,
                                   logic [IDX_W-1:0] col, logic [VALUE_W-1:0] value);
            int                    n;
            int                    slot;
            logic [DATA_WIDTH-1:0] acc;
            product_elem_t         e;
            slot = row * MAX_DIM + col;
            if (func == FUNC_WR_A) begin
                a_store[slot]  = value;
                a_loaded[slot] = 1'b1;
            end else if (func == FUNC_WR_B) begin
                b_store[slot]  = value;
                b_loaded[slot] = 1'b1;
            end else if (func == FUNC_COMPUTE) begin
                n = active_dim();
                for (int i = 0; i < n; i++) begin
                    for (int j = 0; j < n; j++) begin
                        acc = '0;
                        // wraps modulo 2^32, like the hardware accumulator
                        for (int k = 0; k < n; k++)
                            acc = acc + a_store[i * MAX_DIM + k] * b_store[k * MAX_DIM + j];
                        e.row   = IDX_W'(i);
                        e.col   = IDX_W'(j);
                        e.value = acc;
                        e.last  = (i == n - 1) && (j == n - 1);
                        pending_elements.push_back(e);
                    end
                end
            end
        endfunction

        // Called once per accepted product element
        function void match_element(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                                    logic [VALUE_W-1:0] value, logic last);
            product_elem_t e;
            if (pending_elements.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 50)
                    $display("%0t: unexpected element, expected none, ", $time,
                             "actual row %0d col %0d value %h last %b",
                             row, col, value, last);
                return;
            end
            e = pending_elements.pop_front();
            if (e.row !== row || e.col !== col || e.value !== value || e.last !== last) begin
                mismatch_count++;
                if (mismatch_count <= 50)
                    $display("%0t: element mismatch, ", $time,
                             "expected row %0d col %0d value %h last %b, ",
                             e.row, e.col, e.value, e.last,
                             "actual row %0d col %0d value %h last %b",
                             row, col, value, last);
            end
        endfunction
    endclass

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata   = '0;   // row_index[2:0], col_index[5:3], element_value[37:6]
    logic [FUNC_W-1:0]  s_tuser   = FUNC_WR_A;   // func[1:0]
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [TDATA_W-1:0] m_tdata;   // out_row[2:0], out_col[5:3], product_value[37:6]
    logic               m_tlast;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [SIZE_W-1:0]  cfg_data  = '0;

    product_tracker tracker = new();

    bit calm         = 1'b0;   // both sides stop idling while set
    bit hold_request = 1'b0;   // asks the receiver for one long hold-off
    int item_count   = 0;

    square_matrix_multiply_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Element values lean on the signed extremes to exercise wrapping
    function automatic logic [VALUE_W-1:0] pick_element();
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return 32'h0000_0000;
            4:       return VALUE_W'($signed($urandom_range(16)) - 8);
            default: return $urandom;
        endcase
    endfunction

    // Size mix: mostly small, the big and out-of-range ones only late
    function automatic logic [SIZE_W-1:0] pick_size(bit allow_big);
        case ($urandom_range(9))
            0:       return 0;
            1:       return 1;
            2, 3:    return 2;
            4, 5:    return 3;
            6:       return 4;
            7:       return SIZE_W'($urandom_range(5, 7));
            8:       return allow_big ? SIZE_W'(MAX_DIM) : SIZE_W'(2);
            default: return allow_big ? SIZE_W'($urandom_range(9, 15)) : SIZE_W'(4);
        endcase
    endfunction

    // Offer one request with random idle gaps in front; returns after the
    // handshake and records the request in the tracker.
    task automatic send_request(input logic [FUNC_W-1:0] func, input logic [IDX_W-1:0] row,
                                input logic [IDX_W-1:0] col, input logic [VALUE_W-1:0] value);
        while (!calm && $urandom_range(99) < 9) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= TDATA_W'({value, col, row});
        do @(posedge aclk); while (!s_tready);
        tracker.take_request(func, row, col, value);
    endtask

    // Size writes happen only with the block idle: no results outstanding
    // and a quiet wait for trailing element writes to settle.
    task automatic write_size(input logic [SIZE_W-1:0] v);
        s_tvalid <= 1'b0;
        while (tracker.pending_elements.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tracker.set_dim(v);
    endtask

    // Write every A/B entry the next compute will read but that was
    // never written since reset; unwritten entries are undefined.
    task automatic fill_operands();
        int n;
        n = tracker.active_dim();
        for (int i = 0; i < n; i++) begin
            for (int k = 0; k < n; k++) begin
                if (!tracker.a_loaded[i * MAX_DIM + k]) begin
                    send_request(FUNC_WR_A, IDX_W'(i), IDX_W'(k), pick_element());
                    item_count++;
                end
                if (!tracker.b_loaded[i * MAX_DIM + k]) begin
                    send_request(FUNC_WR_B, IDX_W'(i), IDX_W'(k), pick_element());
                    item_count++;
                end
            end
        end
    endtask

    // Result side: check every accepted element, drive m_tready with
    // random stalls, and serve one long hold-off on request.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                tracker.match_element(m_tdata[2:0], m_tdata[5:3], m_tdata[37:6], m_tlast);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
                m_tready     <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 9);
            end
        end
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("** square_matrix_multiply_top: FAILED **");
        $finish;
    end

    // Stimulus: reset, directed cases, then random phases
    initial begin
        logic [VALUE_W-1:0] corner_a[4];
        logic [VALUE_W-1:0] corner_b[4];
        logic [FUNC_W-1:0]  wr_func;
        int                 phase;
        int                 rounds;
        int                 loads;
        int                 n;
        int                 r;

        corner_a = '{32'hffff_ffff, 32'h0000_0001, 32'h8000_0000, 32'h7fff_ffff};
        corner_b = '{32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff, 32'h0000_0000};

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // 1x1: max times min, wrapped
        write_size(1);
        send_request(FUNC_WR_A, 0, 0, 32'h7fff_ffff);
        send_request(FUNC_WR_B, 0, 0, 32'h8000_0000);
        // ignored fields of a compute set to all ones
        send_request(FUNC_COMPUTE, 7, 7, 32'hffff_ffff);
        // unused func code: no state change, no results
        send_request(FUNC_UNUSED, 7, 7, 32'hffff_ffff);

        // 2x2 with signed extremes in every corner
        write_size(2);
        for (int idx = 0; idx < 4; idx++) begin
            send_request(FUNC_WR_A, IDX_W'(idx[1]), IDX_W'(idx[0]), corner_a[idx]);
            send_request(FUNC_WR_B, IDX_W'(idx[1]), IDX_W'(idx[0]), corner_b[idx]);
        end
        send_request(FUNC_COMPUTE, 0, 0, 32'h0);

        // highest row/column address, alternating value bits
        send_request(FUNC_WR_A, 7, 7, 32'h5555_5555);
        send_request(FUNC_WR_B, 7, 7, 32'haaaa_aaaa);

        // size 0 behaves as 1
        write_size(0);
        send_request(FUNC_COMPUTE, 3, 5, 32'h1234_5678);

        // Random phases: a size write (usually), then one or two rounds of
        // element loads - mostly inside the active square - and a compute.
        phase = 0;
        while (item_count < RANDOM_ITEMS) begin
            calm = (phase == 4) || (phase == 5);
            if (phase == 0 || $urandom_range(3) != 0)
                write_size(pick_size(item_count > 60));
            // long receiver hold-off while loads and computes keep coming
            if (phase == 2)
                hold_request = 1'b1;
            rounds = (phase == 2) ? 2 : $urandom_range(1, 2);
            repeat (rounds) begin
                n     = tracker.active_dim();
                loads = $urandom_range(1, n * n + 2);
                repeat (loads) begin
                    r       = $urandom_range(99);
                    wr_func = $urandom_range(1) ? FUNC_WR_B : FUNC_WR_A;
                    if (r < 80) begin
                        send_request(wr_func, IDX_W'($urandom_range(n - 1)),
                                     IDX_W'($urandom_range(n - 1)), pick_element());
                        item_count++;
                    end else if (r < 90) begin
                        send_request(wr_func, IDX_W'($urandom_range(7)),
                                     IDX_W'($urandom_range(7)), pick_element());
                        item_count++;
                    end else begin
                        // noise the block should drop
                        send_request(FUNC_UNUSED, IDX_W'($urandom_range(7)),
                                     IDX_W'($urandom_range(7)), $urandom);
                    end
                end
                fill_operands();
                send_request(FUNC_COMPUTE, IDX_W'($urandom_range(7)),
                             IDX_W'($urandom_range(7)), $urandom);
                item_count++;
            end
            phase++;
        end
        calm = 1'b0;

        // Drain: all elements back, then a quiet tail to catch extras
        s_tvalid <= 1'b0;
        while (tracker.pending_elements.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES + MAX_DIM) @(posedge aclk);

        if (tracker.mismatch_count == 0 && tracker.pending_elements.size() == 0)
            $display("** square_matrix_multiply_top: PASSED **");
        else
            $display("** square_matrix_multiply_top: FAILED **");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/smm_pkg.sv
hw/rtl/smm_ram.sv
hw/rtl/smm_mac.sv
hw/rtl/smm_seq.sv
hw/rtl/square_matrix_multiply_top.sv
tb/sv/tb_square_matrix_multiply_top.sv
